/* rtl/gpr_pkg.sv */
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared types, register indexes and byte-lane helpers for the GPIO port
// register block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpr_pkg;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access sizes (code three behaves as a word)
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_WORD3 = 2'd3;

    // Field widths
    localparam int OFFSET_W = 10;
    localparam int SIZE_W   = 2;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = OFFSET_W - 2;
    localparam int HALF_W   = 16;

    // Register word indexes (byte offset bits 9..2)
    localparam logic [INDEX_W-1:0] IDX_MODE  = 8'd0;
    localparam logic [INDEX_W-1:0] IDX_OTYPE = 8'd1;
    localparam logic [INDEX_W-1:0] IDX_SPEED = 8'd2;
    localparam logic [INDEX_W-1:0] IDX_PULL  = 8'd3;
    localparam logic [INDEX_W-1:0] IDX_IDR   = 8'd4;
    localparam logic [INDEX_W-1:0] IDX_ODR   = 8'd5;
    localparam logic [INDEX_W-1:0] IDX_BSRR  = 8'd6;
    localparam logic [INDEX_W-1:0] IDX_LOCK  = 8'd7;
    localparam logic [INDEX_W-1:0] IDX_AFL   = 8'd8;
    localparam logic [INDEX_W-1:0] IDX_AFH   = 8'd9;

    // One bus access
    typedef struct packed {
        logic                opcode;
        logic [OFFSET_W-1:0] byte_offset;
        logic [SIZE_W-1:0]   access_size;
        logic [DATA_W-1:0]   write_data;
    } gpr_access_t;

    // Low-aligned lane mask for an access size
    function automatic logic [DATA_W-1:0] lane_mask(input logic [SIZE_W-1:0] size);
        logic [DATA_W-1:0] m;
        case (size)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_HALF: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Selected lanes shifted down to bit 0
    function automatic logic [DATA_W-1:0] lane_read(input logic [DATA_W-1:0] value,
                                                    input logic [1:0]        sub,
                                                    input logic [SIZE_W-1:0] size);
        logic [4:0] sh;
        sh = {sub, 3'b000};
        if (size[1])
            return value;
        return (value >> sh) & lane_mask(size);
    endfunction

    // Write data placed on its lanes; the lane above bit 31 drops out
    function automatic logic [DATA_W-1:0] lane_place(input logic [DATA_W-1:0] data,
                                                     input logic [1:0]        sub,
                                                     input logic [SIZE_W-1:0] size);
        logic [4:0] sh;
        sh = {sub, 3'b000};
        if (size[1])
            return data;
        return (data & lane_mask(size)) << sh;
    endfunction

    // Merge written lanes into the old register value
    function automatic logic [DATA_W-1:0] lane_merge(input logic [DATA_W-1:0] old,
                                                     input logic [DATA_W-1:0] data,
                                                     input logic [1:0]        sub,
                                                     input logic [SIZE_W-1:0] size);
        logic [4:0]        sh;
        logic [DATA_W-1:0] m;
        sh = {sub, 3'b000};
        m  = size[1] ? {DATA_W{1'b1}} : (lane_mask(size) << sh);
        return (old & ~m) | lane_place(data, sub, size);
    endfunction

endpackage

/* rtl/gpio_port_register_file_core.sv */
// ----------------------------------------------------------------------------
// gpio_port_register_file_core
// GPIO port register block: one bus access per transfer, one result each.
// ----------------------------------------------------------------------------
// Each slave transfer is one read or write access; each produces exactly one
// master transfer carrying the read result (zero for writes). Accesses flow
// at one per clock while the master side is ready: a transfer lands in the input
// register, and on the next edge that the result register is free the
// register file performs the write or the lane read and the result is
// registered. Throughput is set by the single decode-and-merge path between
// those two registers. Register updates take effect at the edge the access
// leaves the input register, in arrival order.
`timescale 1ns / 1ps

module gpio_port_register_file_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] byte_offset, [11:10] access_size, [43:12] write_data, [47:44] zero
    input  logic [47:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_data
    output logic [31:0] m_axis_tdata
);

    gpr_pkg::gpr_access_t in_access;
    gpr_pkg::gpr_access_t held_access;
    logic                 held_valid;
    logic                 can_load;
    logic                 advance;
    logic [31:0]          read_data;

    // Unpack the slave transfer
    assign in_access.opcode      = s_axis_tuser;
    assign in_access.byte_offset = s_axis_tdata[9:0];
    assign in_access.access_size = s_axis_tdata[11:10];
    assign in_access.write_data  = s_axis_tdata[43:12];

    // Move the held access into the result register when it is free
    assign advance = held_valid && can_load;

    gpr_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_access (in_access),
        .advance   (advance),
        .valid     (held_valid),
        .access    (held_access)
    );

    gpr_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .access    (held_access),
        .read_data (read_data)
    );

    gpr_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .load_data (read_data),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

/* rtl/gpr_in_reg.sv */
// ----------------------------------------------------------------------------
// gpr_in_reg
// Input register: captures one access and holds it until the register file
// takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpr_in_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gpr_pkg::gpr_access_t in_access,
    input  logic                 advance,
    output logic                 valid,
    output gpr_pkg::gpr_access_t access
);

    logic                 valid_reg;
    logic                 valid_next;
    gpr_pkg::gpr_access_t access_reg;

    // Take a new transfer when empty or when the held one leaves now
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on each accepted transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            access_reg <= in_access;
        end
    end

    assign valid  = valid_reg;
    assign access = access_reg;

endmodule

/* rtl/gpr_regfile.sv */
// ----------------------------------------------------------------------------
// gpr_regfile
// Port registers with offset decode, byte-lane merge on writes and lane
// extraction on reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpr_regfile
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  gpr_pkg::gpr_access_t         access,
    output logic [gpr_pkg::DATA_W-1:0]   read_data
);

    logic [gpr_pkg::DATA_W-1:0]  mode_reg,  mode_next;
    logic [gpr_pkg::HALF_W-1:0]  otype_reg, otype_next;
    logic [gpr_pkg::DATA_W-1:0]  speed_reg, speed_next;
    logic [gpr_pkg::DATA_W-1:0]  pull_reg,  pull_next;
    logic [gpr_pkg::HALF_W-1:0]  level_reg, level_next;
    logic [gpr_pkg::DATA_W-1:0]  lock_reg,  lock_next;
    logic [gpr_pkg::DATA_W-1:0]  afl_reg,   afl_next;
    logic [gpr_pkg::DATA_W-1:0]  afh_reg,   afh_next;

    logic [gpr_pkg::INDEX_W-1:0] idx;
    logic [1:0]                  sub;
    logic [gpr_pkg::DATA_W-1:0]  sel_value;
    logic                        sel_mapped;
    logic [gpr_pkg::DATA_W-1:0]  set_reset;
    logic [gpr_pkg::DATA_W-1:0]  otype_wide;
    logic [gpr_pkg::DATA_W-1:0]  level_wide;
    logic                        is_write;

    assign idx      = access.byte_offset[gpr_pkg::OFFSET_W-1:2];
    assign sub      = access.byte_offset[1:0];
    assign is_write = (access.opcode == gpr_pkg::OP_WRITE);

    // Select the register a read addresses
    always_comb
    begin
        sel_value  = '0;
        sel_mapped = 1'b1;
        case (idx)
            gpr_pkg::IDX_MODE:  sel_value = mode_reg;
            gpr_pkg::IDX_OTYPE: sel_value = {16'h0000, otype_reg};
            gpr_pkg::IDX_SPEED: sel_value = speed_reg;
            gpr_pkg::IDX_PULL:  sel_value = pull_reg;
            gpr_pkg::IDX_ODR:   sel_value = {16'h0000, level_reg};
            gpr_pkg::IDX_LOCK:  sel_value = lock_reg;
            gpr_pkg::IDX_AFL:   sel_value = afl_reg;
            gpr_pkg::IDX_AFH:   sel_value = afh_reg;
            default:            sel_mapped = 1'b0;
        endcase
    end

    // Read result; writes and unmapped words give zero
    assign read_data = (!is_write && sel_mapped)
                       ? gpr_pkg::lane_read(sel_value, sub, access.access_size)
                       : '0;

    assign otype_wide = gpr_pkg::lane_merge({16'h0000, otype_reg}, access.write_data,
                                            sub, access.access_size);
    assign level_wide = gpr_pkg::lane_merge({16'h0000, level_reg}, access.write_data,
                                            sub, access.access_size);
    assign set_reset  = gpr_pkg::lane_place(access.write_data, sub, access.access_size);

    // Compute register updates for a write
    always_comb
    begin
        mode_next  = mode_reg;
        otype_next = otype_reg;
        speed_next = speed_reg;
        pull_next  = pull_reg;
        level_next = level_reg;
        lock_next  = lock_reg;
        afl_next   = afl_reg;
        afh_next   = afh_reg;
        if (step && is_write)
        begin
            case (idx)
                gpr_pkg::IDX_MODE:
                    mode_next = gpr_pkg::lane_merge(mode_reg, access.write_data,
                                                    sub, access.access_size);
                gpr_pkg::IDX_OTYPE:
                    otype_next = otype_wide[gpr_pkg::HALF_W-1:0];
                gpr_pkg::IDX_SPEED:
                    speed_next = gpr_pkg::lane_merge(speed_reg, access.write_data,
                                                     sub, access.access_size);
                gpr_pkg::IDX_PULL:
                    pull_next = gpr_pkg::lane_merge(pull_reg, access.write_data,
                                                    sub, access.access_size);
                gpr_pkg::IDX_ODR:
                    level_next = level_wide[gpr_pkg::HALF_W-1:0];
                gpr_pkg::IDX_BSRR:
                    level_next = (level_reg | set_reset[15:0]) & ~set_reset[31:16];
                gpr_pkg::IDX_LOCK:
                    lock_next = gpr_pkg::lane_merge(lock_reg, access.write_data,
                                                    sub, access.access_size);
                gpr_pkg::IDX_AFL:
                    afl_next = gpr_pkg::lane_merge(afl_reg, access.write_data,
                                                   sub, access.access_size);
                gpr_pkg::IDX_AFH:
                    afh_next = gpr_pkg::lane_merge(afh_reg, access.write_data,
                                                   sub, access.access_size);
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= '0;
            otype_reg <= '0;
            speed_reg <= '0;
            pull_reg  <= '0;
            level_reg <= '0;
            lock_reg  <= '0;
            afl_reg   <= '0;
            afh_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            otype_reg <= otype_next;
            speed_reg <= speed_next;
            pull_reg  <= pull_next;
            level_reg <= level_next;
            lock_reg  <= lock_next;
            afl_reg   <= afl_next;
            afh_reg   <= afh_next;
        end
    end

    // A read never disturbs the register contents
    a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !is_write) |=>
            ($stable(mode_reg) && $stable(otype_reg) && $stable(speed_reg) &&
             $stable(pull_reg) && $stable(level_reg) && $stable(lock_reg) &&
             $stable(afl_reg) && $stable(afh_reg)))
        else $error("register changed on a read");

    // A write beyond the map is dropped
    a_unmapped_write_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_write && (idx > gpr_pkg::IDX_AFH)) |=>
            ($stable(mode_reg) && $stable(otype_reg) && $stable(speed_reg) &&
             $stable(pull_reg) && $stable(level_reg) && $stable(lock_reg) &&
             $stable(afl_reg) && $stable(afh_reg)))
        else $error("unmapped write changed a register");

    // A word write to the set/reset register sets, then clears output bits
    a_set_reset_word: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_write && (idx == gpr_pkg::IDX_BSRR) && access.access_size[1]) |=>
            (level_reg == (($past(level_reg) | $past(access.write_data[15:0])) &
                           ~$past(access.write_data[31:16]))))
        else $error("set/reset update wrong");

    // A word write to output type keeps only the low half
    a_otype_word: assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_write && (idx == gpr_pkg::IDX_OTYPE) && access.access_size[1]) |=>
            (otype_reg == $past(access.write_data[15:0])))
        else $error("output type word write wrong");

endmodule

/* rtl/gpr_out_reg.sv */
// ----------------------------------------------------------------------------
// gpr_out_reg
// Result register: holds one read result until the downstream side takes
// it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpr_out_reg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [gpr_pkg::DATA_W-1:0] load_data,
    output logic                       can_load,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gpr_pkg::DATA_W-1:0] out_data
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [gpr_pkg::DATA_W-1:0] data_reg;

    // Free when empty or when the held result transfers now
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
